[rtl/prime_test_and_next_prime_macros.svh]
// Assertion helpers for the prime search block
`ifndef PRIME_TEST_AND_NEXT_PRIME_MACROS_SVH
`define PRIME_TEST_AND_NEXT_PRIME_MACROS_SVH

// check an implication at every rising clock edge outside reset
`define PTNP_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

[rtl/ptnp_pkg.sv]
package ptnp_pkg;

	localparam int unsigned NEXT_W = 31;

	typedef enum logic {
		KIND_TEST = 1'b0,
		KIND_NEXT = 1'b1
	} kind_t;

	// job handed from front to back
	typedef struct packed {
		logic        kind;
		logic [63:0] value;
	} job_t;

endpackage

[rtl/ptnp_front.sv]
module ptnp_front import ptnp_pkg::*; #(
	parameter int DATA_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        in_kind,
	input  logic [31:0] in_number,
	output logic        job_valid,
	input  logic        job_ready,
	output job_t        job
);

	// two-entry queue
	job_t       q_mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	job_t       in_job;
	logic [63:0] ext;
	logic       push, pop;

	// take low DATA_WIDTH bits of the 32-bit field, sign-extend from bit DATA_WIDTH-1
	always_comb begin
		ext = {32'b0, in_number};
		for (int i = 0; i < 64; i++) begin
			if (i >= DATA_WIDTH) ext[i] = ext[DATA_WIDTH-1];
		end
		in_job.kind  = in_kind;
		in_job.value = ext;
	end

	assign in_ready  = (cnt_q != 2'd2);
	assign push      = in_valid && in_ready;
	assign job_valid = (cnt_q != 2'd0);
	assign pop       = job_valid && job_ready;
	assign job       = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) q_mem_q[wr_ptr_q] <= in_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

[rtl/ptnp_divmod.sv]
module ptnp_divmod #(
	parameter int W = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quot,
	output logic [W-1:0] rem
);

	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  q_q, r_q, d_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [W:0]    trial;

	// one quotient bit per cycle, restoring
	assign trial = {r_q, q_q[W-1]} - {1'b0, d_q};
	assign quot  = q_q;
	assign rem   = r_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (busy_q) begin
			if (!trial[W]) begin
				r_q <= trial[W-1:0];
				q_q <= {q_q[W-2:0], 1'b1};
			end else begin
				r_q <= {r_q[W-2:0], q_q[W-1]};
				q_q <= {q_q[W-2:0], 1'b0};
			end
		end
	end

endmodule

[rtl/ptnp_back.sv]
module ptnp_back import ptnp_pkg::*; #(
	parameter int DATA_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        job_valid,
	output logic        job_ready,
	input  job_t        job,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        out_prime_flag,
	output logic [30:0] out_next_value,
	output logic        out_overflow
);

	localparam int W = DATA_WIDTH;
	localparam logic [W-1:0] MAX_POS = {1'b0, {(W-1){1'b1}}};

	typedef enum logic [2:0] {
		ST_IDLE, ST_CAND, ST_DIV, ST_WAIT, ST_OUT
	} state_t;

	state_t        state_q;
	logic          kind_q;
	logic [W-1:0]  cand_q, div_q;
	logic          second_q;
	logic          start_q;
	logic          done;
	logic [W-1:0]  quot, rem;
	logic          neg;

	ptnp_divmod #(.W(W)) u_div (
		.clk(clk), .arst_n(arst_n), .start(start_q),
		.dividend(cand_q), .divisor(second_q ? div_q + W'(2) : div_q),
		.done(done), .quot(quot), .rem(rem)
	);

	assign neg       = job.value[W-1];
	assign job_ready = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);

	// job sequencer: take a job, trial-divide each candidate, then advance the search or emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			start_q  <= 1'b0;
			kind_q   <= 1'b0;
			cand_q   <= '0;
			div_q    <= '0;
			second_q <= 1'b0;
			out_prime_flag <= 1'b0;
			out_next_value <= '0;
			out_overflow   <= 1'b0;
		end else begin
			start_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (job_valid) begin
					kind_q <= job.kind;
					out_prime_flag <= 1'b0;
					out_next_value <= '0;
					out_overflow   <= 1'b0;
					if (job.kind == KIND_TEST) begin
						if (neg) state_q <= ST_OUT;
						else begin
							cand_q  <= job.value[W-1:0];
							state_q <= ST_CAND;
						end
					end else if (neg || job.value[W-1:0] < W'(2)) begin
						out_prime_flag <= 1'b1;
						out_next_value <= 31'd2;
						state_q <= ST_OUT;
					end else if (job.value[W-1:0] == MAX_POS) begin
						out_overflow <= 1'b1;
						state_q <= ST_OUT;
					end else begin
						cand_q  <= job.value[W-1:0] + W'(1);
						state_q <= ST_CAND;
					end
				end
				ST_CAND: begin
					if (cand_q == W'(2) || cand_q == W'(3)) begin
						second_q <= 1'b1;
						state_q  <= ST_WAIT;
					end else if (cand_q <= W'(1) || !cand_q[0]) begin
						div_q   <= W'(0);
						state_q <= ST_DIV;
					end else begin
						div_q    <= W'(3);
						second_q <= 1'b0;
						start_q  <= 1'b1;
						state_q  <= ST_DIV;
					end
				end
				ST_DIV: begin
					// div_q==0 marks composite; div_q==3 checks mod 3
					if (div_q == W'(0)) begin
						second_q <= 1'b0;
						state_q  <= ST_WAIT;
					end else if (done) begin
						if (div_q == W'(3)) begin
							if (rem == '0) div_q <= W'(0);
							else begin
								div_q   <= W'(5);
								start_q <= 1'b1;
							end
						end else if (!second_q) begin
							// stop once the divisor exceeds n / divisor
							if (quot < div_q) begin
								second_q <= 1'b1;
								state_q  <= ST_WAIT;
							end else if (rem == '0) begin
								div_q <= W'(0);
							end else begin
								second_q <= 1'b1;
								start_q  <= 1'b1;
							end
						end else if (rem == '0) begin
							div_q <= W'(0);
						end else begin
							second_q <= 1'b0;
							div_q    <= div_q + W'(6);
							start_q  <= 1'b1;
						end
					end
				end
				ST_WAIT: begin
					// second_q holds the verdict here
					if (kind_q == KIND_TEST) begin
						out_prime_flag <= second_q;
						state_q <= ST_OUT;
					end else if (second_q) begin
						out_prime_flag <= 1'b1;
						out_next_value <= 31'(cand_q);
						state_q <= ST_OUT;
					end else if (cand_q == MAX_POS) begin
						out_overflow <= 1'b1;
						state_q <= ST_OUT;
					end else begin
						cand_q  <= cand_q + W'(1);
						state_q <= ST_CAND;
					end
				end
				ST_OUT: if (out_ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[rtl/prime_test_and_next_prime.sv]
// Operation: trial division, one divide per divisor tried (a mod-3 divide first),
// roughly sqrt(n)/3 divisors per odd candidate, repeated over the prime gap in next
// mode; trivial cases skip the divider.
// Throughput: one item at a time in the back end; a two-entry queue buffers input.
// Reset: arst_n asynchronous active low clears the queue and the sequencer.
module prime_test_and_next_prime import ptnp_pkg::*; #(
	parameter int DATA_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata, // number
	input  logic        s_axis_tuser, // kind
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata, // next_value[30:0], overflow
	output logic        m_axis_tuser  // prime_flag
);

	logic        job_valid, job_ready;
	job_t        job;
	logic [30:0] next_value;
	logic        overflow;

	ptnp_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_kind(s_axis_tuser), .in_number(s_axis_tdata),
		.job_valid(job_valid), .job_ready(job_ready), .job(job)
	);

	ptnp_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
		.clk(clk), .arst_n(arst_n),
		.job_valid(job_valid), .job_ready(job_ready), .job(job),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_prime_flag(m_axis_tuser), .out_next_value(next_value),
		.out_overflow(overflow)
	);

	assign m_axis_tdata = {overflow, next_value};

endmodule

[rtl/ptnp_checker.sv]
`include "prime_test_and_next_prime_macros.svh"
module ptnp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic        m_axis_tuser
);

	`PTNP_ASSERT(a_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "valid dropped")
	`PTNP_ASSERT(a_ovf_flag, clk, arst_n, m_axis_tvalid && m_axis_tdata[31] |-> !m_axis_tuser, "overflow with prime")
	`PTNP_ASSERT(a_ovf_zero, clk, arst_n, m_axis_tvalid && m_axis_tdata[31] |-> m_axis_tdata[30:0] == 31'd0, "overflow value")
	`PTNP_ASSERT(a_next_odd, clk, arst_n, m_axis_tvalid && m_axis_tdata[30:0] > 31'd2 |-> m_axis_tdata[0], "even next")

endmodule

bind prime_test_and_next_prime ptnp_checker u_chk (.*);

[bench/prime_checker.sv]
module prime_checker import ptnp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,
	input  logic        s_axis_tuser,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [31:0] m_axis_tdata,
	input  logic        m_axis_tuser,
	output int          errors,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint unsigned MAX_POS = 64'h7fff_ffff;

	typedef struct packed {
		logic              prime_flag;
		logic [NEXT_W-1:0] next_value;
		logic              overflow;
	} verdict_t;

	verdict_t expected_verdicts[$];

	function automatic bit trial_prime(longint unsigned v);
		longint unsigned d;
		if (v == 2 || v == 3)
			return 1;
		if (v <= 1 || v % 2 == 0 || v % 3 == 0)
			return 0;
		for (d = 5; d <= v / d; d += 6) begin
			if (v % d == 0 || v % (d + 2) == 0)
				return 0;
		end
		return 1;
	endfunction

	function automatic verdict_t predict_verdict(kind_t kind, logic [31:0] number);
		verdict_t r;
		longint unsigned c;
		r = '0;
		if (kind == KIND_TEST) begin
			r.prime_flag = !number[31] && trial_prime(longint'(number));
		end else if (number[31] || number < 32'd2) begin
			r.prime_flag = 1'b1;
			r.next_value = 31'd2;
		end else begin
			c = longint'(number) + 1;
			while (c <= MAX_POS && !trial_prime(c))
				c++;
			if (c <= MAX_POS) begin
				r.prime_flag = 1'b1;
				r.next_value = c[NEXT_W-1:0];
			end else begin
				r.overflow = 1'b1;
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	initial begin
		errors = 0;
		pending = 0;
	end

	always @(posedge clk) begin
		verdict_t want;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				expected_verdicts.push_back(predict_verdict(kind_t'(s_axis_tuser), s_axis_tdata));
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_verdicts.size() == 0) begin
					report_mismatch("unexpected result", m_axis_tdata, 0);
				end else begin
					want = expected_verdicts.pop_front();
					if (m_axis_tuser !== want.prime_flag)
						report_mismatch("prime_flag", m_axis_tuser, want.prime_flag);
					if (m_axis_tdata[30:0] !== want.next_value)
						report_mismatch("next_value", m_axis_tdata[30:0], want.next_value);
					if (m_axis_tdata[31] !== want.overflow)
						report_mismatch("overflow", m_axis_tdata[31], want.overflow);
				end
			end
			pending = expected_verdicts.size();
		end
	end
endmodule

[bench/testbench.sv]
module testbench import ptnp_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 3000000;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0; // number
	logic        s_axis_tuser = 0;  // kind
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [31:0] m_axis_tdata;      // next_value[30:0], overflow
	logic        m_axis_tuser;      // prime_flag
	int          errors;
	int          pending;
	int          idle_pct = 0;
	int          stall_pct = 0;
	int          quiet_cycles = 0;

	always #1 clk = ~clk;

	prime_test_and_next_prime dut (.*);

	prime_checker checker_i (.*);

	always @(posedge clk)
		m_axis_tready <= ($urandom_range(99) >= stall_pct);

	// end the run when no transaction moves for too long
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic send_number(kind_t kind, logic [31:0] number);
		if ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 0;
			@(posedge clk);
			while ($urandom_range(99) < idle_pct)
				@(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tuser  <= kind;
		s_axis_tdata  <= number;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic send_random();
		kind_t kind;
		logic [31:0] number;
		int pick;
		kind = kind_t'($urandom_range(1));
		pick = $urandom_range(99);
		if (pick < 70) begin
			number = $urandom_range(5000);
		end else if (pick < 85 || kind == KIND_NEXT) begin
			number = {1'b1, 31'($urandom)};
		end else begin
			// large even values skip the divide loop
			number = $urandom;
			number[0] = 0;
		end
		send_number(kind, number);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send_number(KIND_TEST, 32'h8000_0000);
		send_number(KIND_TEST, 32'hffff_ffff);
		send_number(KIND_TEST, 0);
		send_number(KIND_TEST, 1);
		send_number(KIND_TEST, 2);
		send_number(KIND_TEST, 3);
		send_number(KIND_TEST, 4);
		send_number(KIND_TEST, 5);
		send_number(KIND_TEST, 9);
		send_number(KIND_TEST, 25);
		send_number(KIND_TEST, 49);
		send_number(KIND_TEST, 97);
		send_number(KIND_TEST, 32'h7fff_fffe);
		send_number(KIND_TEST, 32'h7fff_ffff);
		send_number(KIND_NEXT, 32'h8000_0000);
		send_number(KIND_NEXT, 32'hffff_ffff);
		send_number(KIND_NEXT, 0);
		send_number(KIND_NEXT, 1);
		send_number(KIND_NEXT, 2);
		send_number(KIND_NEXT, 3);
		send_number(KIND_NEXT, 13);
		send_number(KIND_NEXT, 24);
		send_number(KIND_NEXT, 89);
		send_number(KIND_NEXT, 32'h7fff_ffff);
		drain_results();

		for (int phase = 0; phase < 4; phase++) begin
			idle_pct  = (phase == 1) ? 83 : (phase == 3) ? 37 : 0;
			stall_pct = (phase == 2) ? 83 : (phase == 3) ? 37 : 0;
			repeat (25)
				send_random();
			drain_results();
		end

		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule

[files.f]
+incdir+rtl
rtl/ptnp_pkg.sv
rtl/ptnp_front.sv
rtl/ptnp_divmod.sv
rtl/ptnp_back.sv
rtl/prime_test_and_next_prime.sv
rtl/ptnp_checker.sv
bench/prime_checker.sv
bench/testbench.sv
